// ===== hw/rtl/lcgs_pkg.sv =====
// lcgs_pkg: shared types and constants of the seeded lcg shuffle block
// used by lcgs_step, lcgs_serial and seeded_lcg_shuffle_top; no dependencies
package lcgs_pkg;

  localparam int unsigned MaxCount = 8;
  localparam int unsigned NumRegs = 5;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned RecipShift = 20;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgInc = 32'd1013904223;

  typedef logic [2:0] elem_t;
  typedef elem_t [MaxCount-1:0] order_t;
  typedef logic [7:0] value_t;
  typedef value_t [NumRegs-1:0] value_bank_t;

  // one pipeline slot: generator state and the partly shuffled order
  typedef struct packed {
    logic   vld;
    logic [31:0] r;
    order_t ord;
  } stage_t;

  localparam value_bank_t ResetValues = {8'd22, 8'd16, 8'd11, 8'd7, 8'd3};

  function automatic order_t identity_order();
    order_t ord;
    for (int k = 0; k < MaxCount; k++) begin
      ord[k] = elem_t'(k);
    end
    return ord;
  endfunction

endpackage

// ===== hw/rtl/lcgs_step.sv =====
// lcgs_step: one shuffle step in three register stages
// advance generator, reduce bits 31..16 modulo STEP+1, swap; uses lcgs_pkg
module lcgs_step #(
  parameter int unsigned STEP = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  lcgs_pkg::stage_t din,
  output lcgs_pkg::stage_t dout
);

  localparam int unsigned Div = STEP + 1;
  localparam logic [20:0] Recip = 21'((1 << lcgs_pkg::RecipShift) / Div);
  localparam logic [15:0] DivW = 16'(Div);
  localparam logic [2:0] StepIdx = 3'(STEP);

  logic             a_vld;
  logic [31:0]      a_r;
  lcgs_pkg::order_t a_ord;

  logic             b_vld;
  logic [31:0]      b_r;
  logic [15:0]      b_q;
  lcgs_pkg::order_t b_ord;

  logic             c_vld;
  logic [31:0]      c_r;
  lcgs_pkg::order_t c_ord;

  logic [31:0]      a_r_next;
  logic [35:0]      qm;
  logic [15:0]      qd;
  logic [15:0]      rem;
  logic [15:0]      rem_fix;
  logic [2:0]       j;
  lcgs_pkg::order_t swapped;

  assign a_r_next = din.r * lcgs_pkg::LcgMul + lcgs_pkg::LcgInc;

  // quotient estimate by reciprocal, low by at most one
  assign qm = 36'(a_r[31:16]) * 36'(Recip);

  assign qd      = b_q * DivW;
  assign rem     = b_r[31:16] - qd;
  assign rem_fix = (rem >= DivW) ? (rem - DivW) : rem;
  assign j       = rem_fix[2:0];

  always_comb begin
    swapped = b_ord;
    swapped[StepIdx] = b_ord[j];
    swapped[j] = b_ord[StepIdx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= din.vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= a_r_next;
      a_ord <= din.ord;
      b_r   <= a_r;
      b_q   <= qm[35:20];
      b_ord <= a_ord;
      c_r   <= b_r;
      c_ord <= swapped;
    end
  end

  assign dout = '{vld: c_vld, r: c_r, ord: c_ord};

endmodule

// ===== hw/rtl/lcgs_serial.sv =====
// lcgs_serial: holds one finished order and sends it out one position per transfer
// looks up element values from the register bank; uses lcgs_pkg
module lcgs_serial #(
  parameter int unsigned COUNT = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lcgs_pkg::stage_t       tail,
  output logic                   load_ok,
  input  lcgs_pkg::value_bank_t  values,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             position,
  output logic [2:0]             element_index,
  output logic [7:0]             element_value,
  output logic                   last
);

  localparam logic [2:0] PosLast = 3'(COUNT - 1);

  logic             busy;
  logic [2:0]       pos;
  lcgs_pkg::order_t ord;

  logic xfer;
  logic load;

  assign xfer    = busy && !out_stall;
  assign last    = (pos == PosLast);
  // a new order may come in on the cycle the final position goes out
  assign load_ok = !busy || (xfer && last);
  assign load    = load_ok && tail.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
        pos  <= '0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ord <= tail.ord;
    end
  end

  assign out_valid     = busy;
  assign position      = pos;
  assign element_index = ord[pos];

  always_comb begin
    if (element_index < 3'(lcgs_pkg::NumRegs)) begin
      element_value = values[element_index];
    end else begin
      element_value = '0;
    end
  end

`ifndef ASSERT_OFF
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && position == $past(position) + 3'd1))
    else $error("position did not advance after a transfer");

  a_run_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!out_valid || position == 3'd0))
    else $error("new run does not start at position zero");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, element_index} < 4'(COUNT)))
    else $error("element index out of range");
`endif

endmodule

// ===== hw/rtl/seeded_lcg_shuffle_top.sv =====
// seeded_lcg_shuffle_top: seeded fisher-yates shuffle of COUNT valued elements
// depends on lcgs_pkg, lcgs_step and lcgs_serial
//
// Each seed accepted on the input channel (low bit forced to one) drives a 32-bit
// lcg through COUNT-1 shuffle steps; the block then sends COUNT results, one per
// position, with the element index there, its configured value and a last flag.
// Each step is three register stages, and the serializer registers the finished
// order before its first result goes out; the rest follow one per cycle while
// out_stall is low. A new seed can enter every cycle while the pipeline has room;
// sustained, intake is set by the result channel moving one position per transfer.
// The user must write the value registers through the cfg port between runs only,
// since each value is looked up as its result goes out; the block does not enforce
// this. cfg_ready is always high, and writes to indexes above four are dropped.
module seeded_lcg_shuffle_top #(
  parameter int unsigned COUNT = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         seed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          position,
  output logic [2:0]                          element_index,
  output logic [7:0]                          element_value,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcgs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [7:0]                          cfg_data
);

  lcgs_pkg::value_bank_t values;
  lcgs_pkg::stage_t      chain [COUNT];
  logic                  adv;
  logic                  load_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      values <= lcgs_pkg::ResetValues;
    end else if (cfg_valid && cfg_ready) begin
      for (int k = 0; k < lcgs_pkg::NumRegs; k++) begin
        if (cfg_index == lcgs_pkg::CfgIndexWidth'(k)) begin
          values[k] <= cfg_data;
        end
      end
    end
  end

  // whole pipeline moves together; it holds only when the tail cannot hand off
  assign adv      = !chain[COUNT-1].vld || load_ok;
  assign in_stall = !adv;

  assign chain[0] = '{vld: in_valid, r: seed | 32'd1, ord: lcgs_pkg::identity_order()};

  for (genvar s = 0; s < COUNT - 1; s++) begin : g_step
    lcgs_step #(
      .STEP(COUNT - 1 - s)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .din (chain[s]),
      .dout(chain[s+1])
    );
  end

  lcgs_serial #(
    .COUNT(COUNT)
  ) u_serial (
    .clk          (clk),
    .rst          (rst),
    .tail         (chain[COUNT-1]),
    .load_ok      (load_ok),
    .values       (values),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position     (position),
    .element_index(element_index),
    .element_value(element_value),
    .last         (last)
  );

endmodule
